// ----- design/mfd_pkg.sv -----
// ---------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the multitap feedback delay unit.
// ---------------------------------------------------------------------------
`default_nettype none
package mfd_pkg;

  localparam int unsigned BUFFER_FRAMES_DEF = 4096;
  localparam int unsigned MAX_CHANNELS_DEF  = 2;
  localparam int unsigned MAX_TAPS_DEF      = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned PROD_W   = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_SET_DELAY = 2'd1,
    CMD_SET_GAIN  = 2'd2,
    CMD_NONE      = 2'd3
  } mfd_cmd_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_BAD_DELAY = 2'd2;

  localparam logic [2:0] REG_DRY_GAIN      = 3'd0;
  localparam logic [2:0] REG_OUT_GAIN      = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_FF_TAP_COUNT  = 3'd3;
  localparam logic [2:0] REG_FB_TAP_COUNT  = 3'd4;

endpackage
`default_nettype wire

// ----- design/mfd_ram.sv -----
// ---------------------------------------------------------------------------
// mfd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module mfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- design/multitap_feedback_delay_unit.sv -----
// ---------------------------------------------------------------------------
// multitap_feedback_delay_unit
// Multi-tap delay line with feed-forward and feedback taps on interleaved
// audio, one shared 48x16 multiplier and one accumulator under a sequencer.
// ---------------------------------------------------------------------------
// Usage:
//  in_* channel (valid/stall) carries one command word: a sample to process
//  or a tap delay/gain write. out_* channel (valid/stall) returns one result
//  word per command. cfg_* (valid/ready) writes the gain and count registers;
//  the user must write them only while the block is idle, as the block itself
//  does not enforce this; cfg_ready is always high.
//  A sample word steps through the feed-forward and then the feedback taps
//  in use; zero-gain taps are passed over, and every active tap runs one
//  memory read, one multiply and one accumulate through the shared
//  multiplier. in_stall is high while a word is in work, so one word is
//  handled at a time.
//  After reset all BUFFER_FRAMES*MAX_CHANNELS addresses of both sample stores
//  are cleared, one address per cycle; in_stall is held meanwhile.
//  The result sits in an output register; while out_stall holds it the
//  next word may be accepted, and its result waits until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none
module multitap_feedback_delay_unit #(
  parameter int unsigned BUFFER_FRAMES = mfd_pkg::BUFFER_FRAMES_DEF,
  parameter int unsigned MAX_CHANNELS  = mfd_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned MAX_TAPS      = mfd_pkg::MAX_TAPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic signed [15:0] in_sample_in,
  input  wire logic        in_tap_kind,
  input  wire logic [3:0]  in_tap_index,
  input  wire logic [15:0] in_tap_delay,
  input  wire logic signed [15:0] in_tap_gain,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_sample,
  output logic             out_frame_last,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mfd_pkg::*;

  localparam int unsigned DEPTH = BUFFER_FRAMES * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FW    = $clog2(BUFFER_FRAMES);
  localparam int unsigned CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned TIW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned TCW   = $clog2(MAX_TAPS + 1);
  localparam int unsigned SW    = ACC_W + 5;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_ACC_INIT, ST_TAP_SEL, ST_TAP_MUL,
    ST_TAP_ACC, ST_OUT_MUL, ST_OUT_SAT, ST_FINISH
  } state_t;

  state_t state_r;

  // configuration
  logic signed [15:0] dry_gain_r, out_gain_r;
  logic [1:0]         chan_cnt_r;
  logic [3:0]         ff_cnt_r, fb_cnt_r;

  // taps
  logic [FW-1:0]      ff_delay_r [MAX_TAPS];
  logic [FW-1:0]      fb_delay_r [MAX_TAPS];
  logic signed [15:0] ff_gain_r  [MAX_TAPS];
  logic signed [15:0] fb_gain_r  [MAX_TAPS];

  logic [FW-1:0]      fp_r;
  logic [CW-1:0]      ch_r;
  logic [AW-1:0]      clr_addr_r;

  // latched word
  mfd_cmd_t           cmd_r;
  logic signed [15:0] sample_r;
  logic               kind_r;
  logic [3:0]         idx_r;
  logic [15:0]        delay_r;
  logic signed [15:0] gain_r;

  // datapath
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [TCW-1:0]           tap_i_r;
  logic                     fb_phase_r;
  logic                     direct_r;
  logic signed [15:0]       res_sample_r;
  logic                     res_last_r;
  logic [1:0]               res_status_r;
  logic                     out_valid_r;

  // combinational
  logic [TCW-1:0]           ff_lim, fb_lim, cur_lim, wr_lim;
  logic [3:0]               chans_eff;
  logic                     last;
  logic [AW-1:0]            here_addr, past_addr;
  logic [FW:0]              diff;
  logic [FW-1:0]            past_frame;
  logic [TIW-1:0]           tsel;
  logic [FW-1:0]            sel_dly;
  logic signed [15:0]       sel_gain;
  logic signed [ACC_W-1:0]  mul_a;
  logic signed [15:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] rnd12, rnd24;
  logic signed [SW-1:0]     term, sum;
  logic signed [ACC_W-1:0]  sum_sat;
  logic signed [15:0]       y_sat;
  logic                     in_we, out_we;
  logic [AW-1:0]            in_waddr, out_waddr;
  logic [15:0]              in_wdata, out_wdata;
  logic [15:0]              in_rdata, out_rdata;
  logic                     out_free;

  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_free       = !out_valid_r || !out_stall;

  always_comb begin
    ff_lim = ({1'b0, ff_cnt_r} > 5'(MAX_TAPS)) ? TCW'(MAX_TAPS) : TCW'(ff_cnt_r);
    fb_lim = ({1'b0, fb_cnt_r} > 5'(MAX_TAPS)) ? TCW'(MAX_TAPS) : TCW'(fb_cnt_r);
    cur_lim = fb_phase_r ? fb_lim : ff_lim;
    wr_lim  = kind_r ? fb_lim : ff_lim;

    if (chan_cnt_r == 2'd0) begin
      chans_eff = 4'd1;
    end else if ({2'b00, chan_cnt_r} > 4'(MAX_CHANNELS)) begin
      chans_eff = 4'(MAX_CHANNELS);
    end else begin
      chans_eff = {2'b00, chan_cnt_r};
    end
    // a lowered count mid-frame ends the frame here
    last = ((4'(ch_r) + 4'd1) >= chans_eff);

    here_addr = AW'(fp_r) * AW'(MAX_CHANNELS) + AW'(ch_r);

    tsel     = tap_i_r[TIW-1:0];
    sel_dly  = fb_phase_r ? fb_delay_r[tsel] : ff_delay_r[tsel];
    sel_gain = fb_phase_r ? fb_gain_r[tsel]  : ff_gain_r[tsel];

    // delays wrap around the frame ring
    diff = {1'b0, fp_r} - {1'b0, sel_dly};
    if (diff[FW]) begin
      past_frame = FW'(diff + (FW+1)'(BUFFER_FRAMES));
    end else begin
      past_frame = diff[FW-1:0];
    end
    past_addr = AW'(past_frame) * AW'(MAX_CHANNELS) + AW'(ch_r);

    // shared multiplier operands
    case (state_r)
      ST_DECODE: begin
        mul_a = ACC_W'(sample_r);
        mul_b = dry_gain_r;
      end
      ST_TAP_MUL: begin
        if (direct_r) begin
          mul_a = acc_r;
        end else if (fb_phase_r) begin
          mul_a = ACC_W'(signed'(out_rdata));
        end else begin
          mul_a = ACC_W'(signed'(in_rdata));
        end
        mul_b = sel_gain;
      end
      ST_OUT_MUL: begin
        mul_a = acc_r;
        mul_b = out_gain_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;

    rnd12 = (prod_r + 64'sd2048) >>> 12;
    rnd24 = (prod_r + 64'sd8388608) >>> 24;
    term  = direct_r ? SW'(rnd12) : SW'(prod_r);
    sum   = SW'(acc_r) + term;
    if (sum > SW'(ACC_MAX)) begin
      sum_sat = ACC_MAX;
    end else if (sum < SW'(ACC_MIN)) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
    if (rnd24 > 64'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (rnd24 < -64'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = rnd24[15:0];
    end

    // store ports
    in_we     = 1'b0;
    out_we    = 1'b0;
    in_waddr  = here_addr;
    out_waddr = here_addr;
    in_wdata  = sample_r;
    out_wdata = y_sat;
    if (state_r == ST_CLEAR) begin
      in_we     = 1'b1;
      out_we    = 1'b1;
      in_waddr  = clr_addr_r;
      out_waddr = clr_addr_r;
      in_wdata  = '0;
      out_wdata = '0;
    end else if (state_r == ST_DECODE && cmd_r == CMD_SAMPLE) begin
      in_we = 1'b1;
    end else if (state_r == ST_OUT_SAT) begin
      out_we = 1'b1;
    end
  end

  mfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_in_store (
    .clk     (clk),
    .wr_en   (in_we),
    .wr_addr (in_waddr),
    .wr_data (in_wdata),
    .rd_addr (past_addr),
    .rd_data (in_rdata)
  );

  mfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_out_store (
    .clk     (clk),
    .wr_en   (out_we),
    .wr_addr (out_waddr),
    .wr_data (out_wdata),
    .rd_addr (past_addr),
    .rd_data (out_rdata)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      dry_gain_r   <= 16'sd4096;
      out_gain_r   <= 16'sd4096;
      chan_cnt_r   <= 2'd1;
      ff_cnt_r     <= '0;
      fb_cnt_r     <= '0;
      fp_r         <= '0;
      ch_r         <= '0;
      out_valid_r  <= 1'b0;
      tap_i_r      <= '0;
      fb_phase_r   <= 1'b0;
      direct_r     <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        ff_delay_r[i] <= '0;
        fb_delay_r[i] <= '0;
        ff_gain_r[i]  <= '0;
        fb_gain_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRY_GAIN:      dry_gain_r <= cfg_data;
          REG_OUT_GAIN:      out_gain_r <= cfg_data;
          REG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[1:0];
          REG_FF_TAP_COUNT:  ff_cnt_r   <= cfg_data[3:0];
          REG_FB_TAP_COUNT:  fb_cnt_r   <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r    <= mfd_cmd_t'(in_cmd);
            sample_r <= in_sample_in;
            kind_r   <= in_tap_kind;
            idx_r    <= in_tap_index;
            delay_r  <= in_tap_delay;
            gain_r   <= in_tap_gain;
            state_r  <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          res_sample_r <= '0;
          res_last_r   <= 1'b0;
          res_status_r <= STATUS_OK;
          case (cmd_r)
            CMD_SAMPLE: begin
              state_r <= ST_ACC_INIT;
            end
            CMD_SET_DELAY, CMD_SET_GAIN: begin
              state_r <= ST_FINISH;
              if ({1'b0, idx_r} >= 5'(wr_lim)) begin
                res_status_r <= STATUS_BAD_INDEX;
              end else if (cmd_r == CMD_SET_DELAY) begin
                if ({1'b0, delay_r} >= 17'(BUFFER_FRAMES)) begin
                  res_status_r <= STATUS_BAD_DELAY;
                end else if (kind_r) begin
                  fb_delay_r[idx_r[TIW-1:0]] <= FW'(delay_r);
                end else begin
                  ff_delay_r[idx_r[TIW-1:0]] <= FW'(delay_r);
                end
              end else if (kind_r) begin
                fb_gain_r[idx_r[TIW-1:0]] <= gain_r;
              end else begin
                ff_gain_r[idx_r[TIW-1:0]] <= gain_r;
              end
            end
            default: begin
              state_r <= ST_FINISH;
            end
          endcase
        end
        ST_ACC_INIT: begin
          acc_r      <= prod_r[ACC_W-1:0];
          tap_i_r    <= '0;
          fb_phase_r <= 1'b0;
          state_r    <= ST_TAP_SEL;
        end
        ST_TAP_SEL: begin
          if (tap_i_r >= cur_lim) begin
            if (fb_phase_r) begin
              state_r <= ST_OUT_MUL;
            end else begin
              fb_phase_r <= 1'b1;
              tap_i_r    <= '0;
            end
          end else if (sel_gain == 16'sd0) begin
            tap_i_r <= tap_i_r + TCW'(1);
          end else begin
            // feedback with no delay scales the running sum
            direct_r <= fb_phase_r && (sel_dly == '0);
            state_r  <= ST_TAP_MUL;
          end
        end
        ST_TAP_MUL: begin
          state_r <= ST_TAP_ACC;
        end
        ST_TAP_ACC: begin
          acc_r    <= sum_sat;
          direct_r <= 1'b0;
          tap_i_r  <= tap_i_r + TCW'(1);
          state_r  <= ST_TAP_SEL;
        end
        ST_OUT_MUL: begin
          state_r <= ST_OUT_SAT;
        end
        ST_OUT_SAT: begin
          res_sample_r <= y_sat;
          res_last_r   <= last;
          if (last) begin
            ch_r <= '0;
            if ({1'b0, fp_r} + (FW+1)'(1) == (FW+1)'(BUFFER_FRAMES)) begin
              fp_r <= '0;
            end else begin
              fp_r <= fp_r + FW'(1);
            end
          end else begin
            ch_r <= ch_r + CW'(1);
          end
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_sample     <= res_sample_r;
            out_frame_last <= res_last_r;
            out_status     <= res_status_r;
            out_valid_r    <= 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/mfd_checker.sv -----
// ---------------------------------------------------------------------------
// mfd_checker
// Port-level checks of the multitap feedback delay unit, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
module mfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic signed [15:0] out_sample,
  input wire logic        out_frame_last,
  input wire logic [1:0]  out_status
);
  import mfd_pkg::*;

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in work");

  // rejected tap writes carry no sample
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |-> (out_sample == 16'sd0 && !out_frame_last))
    else $error("error status with nonzero sample fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_BAD_INDEX ||
                   out_status == STATUS_BAD_DELAY))
    else $error("unknown status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample) &&
                                  $stable(out_status) && $stable(out_frame_last)))
    else $error("stalled result word changed");

endmodule

bind multitap_feedback_delay_unit mfd_checker u_mfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample     (out_sample),
  .out_frame_last (out_frame_last),
  .out_status     (out_status)
);
`default_nettype wire

// ----- test/tb_multitap_feedback_delay_unit.sv -----
// ---------------------------------------------------------------------------
// tb_multitap_feedback_delay_unit
// Self-checking bench: a queue-fed driver sends sample, tap-write and unused
// command words, a predictor of the delay line computes each result, and a monitor
// compares every result word in order under random idling and stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_multitap_feedback_delay_unit;
  import mfd_pkg::*;

  localparam int FRAMES = 4096;
  localparam int CHANS = 2;
  localparam int TAPS = 8;
  localparam int QUIET_LIMIT = 30000;

  typedef struct {
    mfd_cmd_t cmd;
    logic signed [15:0] sample;
    logic kind;
    logic [3:0] idx;
    logic [15:0] delay;
    logic signed [15:0] gain;
  } word_t;

  typedef struct {
    logic signed [15:0] sample;
    logic last;
    logic [1:0] status;
  } result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic signed [15:0] in_sample_in = '0;
  logic in_tap_kind = 0;
  logic [3:0] in_tap_index = '0;
  logic [15:0] in_tap_delay = '0;
  logic signed [15:0] in_tap_gain = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_sample;
  logic out_frame_last;
  logic [1:0] out_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  multitap_feedback_delay_unit DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] dry_store [FRAMES*CHANS];
  logic signed [15:0] wet_store [FRAMES*CHANS];
  logic [11:0] ff_dly [TAPS];
  logic signed [15:0] ff_g [TAPS];
  logic [11:0] fb_dly [TAPS];
  logic signed [15:0] fb_g [TAPS];
  int frame_pos, chan_pos;
  logic signed [15:0] dry_gain, out_gain;
  logic [1:0] chan_cnt;
  logic [3:0] ff_cnt, fb_cnt;

  word_t pending[$];
  result_t expected[$];
  word_t cur_word;
  int errors = 0;
  int snd_idle_pct = 0, rcv_idle_pct = 0;

  function automatic longint clamp48(longint a);
    if (a > longint'(ACC_MAX)) return longint'(ACC_MAX);
    if (a < longint'(ACC_MIN)) return longint'(ACC_MIN);
    return a;
  endfunction

  function automatic longint round_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int past_addr(int d, int ch);
    return ((frame_pos + FRAMES - d) % FRAMES) * CHANS + ch;
  endfunction

  function automatic int tap_lim(logic [3:0] c);
    return (c > TAPS) ? TAPS : int'(c);
  endfunction

  function automatic void predict_word(word_t w);
    result_t r;
    int chans, ch, here, cnt;
    longint acc, y;
    logic last;
    r.sample = '0;
    r.last = 0;
    r.status = STATUS_OK;
    if (w.cmd == CMD_SAMPLE) begin
      chans = (chan_cnt == 0) ? 1 : ((chan_cnt > CHANS) ? CHANS : int'(chan_cnt));
      ch = chan_pos % CHANS;
      last = (ch + 1 >= chans);
      here = frame_pos * CHANS + ch;
      dry_store[here] = w.sample;
      acc = longint'(w.sample) * longint'(dry_gain);
      for (int i = 0; i < tap_lim(ff_cnt); i++)
        if (ff_g[i] != 0)
          acc = clamp48(acc + longint'(dry_store[past_addr(ff_dly[i], ch)]) * longint'(ff_g[i]));
      for (int i = 0; i < tap_lim(fb_cnt); i++) begin
        if (fb_g[i] == 0) continue;
        if (fb_dly[i] == 0)
          acc = clamp48(acc + round_shift(acc * longint'(fb_g[i]), 12));
        else
          acc = clamp48(acc + longint'(wet_store[past_addr(fb_dly[i], ch)]) * longint'(fb_g[i]));
      end
      y = round_shift(acc * longint'(out_gain), 24);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      wet_store[here] = y[15:0];
      if (last) begin
        chan_pos = 0;
        frame_pos = (frame_pos + 1) % FRAMES;
      end else begin
        chan_pos = ch + 1;
      end
      r.sample = y[15:0];
      r.last = last;
    end else if (w.cmd == CMD_SET_DELAY || w.cmd == CMD_SET_GAIN) begin
      cnt = tap_lim(w.kind ? fb_cnt : ff_cnt);
      if (w.idx >= cnt) begin
        r.status = STATUS_BAD_INDEX;
      end else if (w.cmd == CMD_SET_DELAY) begin
        if (w.delay >= FRAMES) r.status = STATUS_BAD_DELAY;
        else if (w.kind) fb_dly[w.idx] = w.delay[11:0];
        else ff_dly[w.idx] = w.delay[11:0];
      end else begin
        if (w.kind) fb_g[w.idx] = w.gain;
        else ff_g[w.idx] = w.gain;
      end
    end
    expected.push_back(r);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) predict_word(cur_word);
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_word = pending.pop_front();
          in_cmd <= cur_word.cmd;
          in_sample_in <= cur_word.sample;
          in_tap_kind <= cur_word.kind;
          in_tap_index <= cur_word.idx;
          in_tap_delay <= cur_word.delay;
          in_tap_gain <= cur_word.gain;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;

  // one long hold-off to back the block up, counted on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected.size() == 0) begin
          report("unexpected word", out_sample, 0);
        end else begin
          e = expected.pop_front();
          if (out_sample !== e.sample) report("out_sample", out_sample, e.sample);
          if (out_frame_last !== e.last) report("out_frame_last", out_frame_last, e.last);
          if (out_status !== e.status) report("out_status", out_status, e.status);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRY_GAIN: dry_gain = val;
      REG_OUT_GAIN: out_gain = val;
      REG_CHANNEL_COUNT: chan_cnt = val[1:0];
      REG_FF_TAP_COUNT: ff_cnt = val[3:0];
      REG_FB_TAP_COUNT: fb_cnt = val[3:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [15:0] dg, logic [15:0] og, logic [1:0] ch,
                       logic [3:0] nff, logic [3:0] nfb);
    wait_idle();
    write_reg(REG_DRY_GAIN, dg);
    write_reg(REG_OUT_GAIN, og);
    write_reg(REG_CHANNEL_COUNT, 16'(ch));
    write_reg(REG_FF_TAP_COUNT, 16'(nff));
    write_reg(REG_FB_TAP_COUNT, 16'(nfb));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic word_t mk(mfd_cmd_t c, int s, bit k, int i, int d, int g);
    word_t w;
    w.cmd = c;
    w.sample = s[15:0];
    w.kind = k;
    w.idx = i[3:0];
    w.delay = d[15:0];
    w.gain = g[15:0];
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int p;
    w = mk(CMD_SAMPLE, $urandom, 1'($urandom_range(1)), $urandom_range(15), $urandom,
           $urandom);
    p = $urandom_range(99);
    if (p < 68) begin
      w.cmd = CMD_SAMPLE;
      if ($urandom_range(3) == 0) w.sample = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end else if (p < 97) begin
      w.cmd = $urandom_range(1) ? CMD_SET_DELAY : CMD_SET_GAIN;
      if ($urandom_range(9) != 0) w.idx = 4'($urandom_range(TAPS - 1));
      if ($urandom_range(9) != 0) w.delay = 16'($urandom_range(40));
      if ($urandom_range(7) == 0) w.gain = '0;
      else if ($urandom_range(1)) w.gain = $signed(16'($urandom_range(4095))) - 16'sd2048;
    end else begin
      w.cmd = CMD_NONE;
    end
    return w;
  endfunction

  initial begin
    for (int a = 0; a < FRAMES * CHANS; a++) begin
      dry_store[a] = '0;
      wet_store[a] = '0;
    end
    for (int i = 0; i < TAPS; i++) begin
      ff_dly[i] = '0;
      ff_g[i] = '0;
      fb_dly[i] = '0;
      fb_g[i] = '0;
    end
    frame_pos = 0;
    chan_pos = 0;
    dry_gain = 16'sd4096;
    out_gain = 16'sd4096;
    chan_cnt = 2'd1;
    ff_cnt = '0;
    fb_cnt = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // reset settings: taps all rejected, unused command, sample extremes
    pending.push_back(mk(CMD_SAMPLE, 32767, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SAMPLE, -32768, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 0, 0, 0, 100));
    pending.push_back(mk(CMD_NONE, -1, 1, 15, 65535, -1));
    setup(16'h1000, 16'h1000, 2'd2, 4'd8, 4'd8);
    pending.push_back(mk(CMD_SET_DELAY, 0, 0, 8, 3, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 1, 15, 0, 7));
    pending.push_back(mk(CMD_SET_DELAY, 0, 0, 1, 4096, 0));
    pending.push_back(mk(CMD_SET_DELAY, 0, 1, 1, 65535, 0));
    pending.push_back(mk(CMD_SET_DELAY, 0, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 0, 0, 0, 4096));
    pending.push_back(mk(CMD_SET_DELAY, 0, 0, 7, 4095, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 0, 7, 0, -32768));
    pending.push_back(mk(CMD_SET_DELAY, 0, 1, 0, 0, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 1, 0, 0, 32767));
    pending.push_back(mk(CMD_SET_DELAY, 0, 1, 1, 1, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 1, 1, 0, -2048));
    pending.push_back(mk(CMD_SAMPLE, 32767, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SAMPLE, -32768, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0));
    // count lowered mid-frame: next sample closes its frame
    setup(16'h1000, 16'h1000, 2'd1, 4'd8, 4'd8);
    pending.push_back(mk(CMD_SAMPLE, 1234, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SAMPLE, -4321, 0, 0, 0, 0));
    setup(16'h1000, 16'h1000, 2'd2, 4'd8, 4'd8);
    pending.push_back(mk(CMD_SET_GAIN, 0, 1, 0, 0, 0));
    pending.push_back(mk(CMD_SET_GAIN, 0, 0, 7, 0, 0));

    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0: setup(16'h1000, 16'h1000, 2'd2, 4'd4, 4'd2);
        1: setup(16'h8000, 16'h7fff, 2'd0, 4'd15, 4'd0);
        2: setup(16'h7fff, 16'h8000, 2'd3, 4'd0, 4'd15);
        3: setup(16'h0800, 16'h2000, 2'd2, 4'd8, 4'd8);
        4: setup(16'(-4096), 16'h0fff, 2'd1, 4'd3, 4'd5);
        default: setup(16'($urandom), 16'($urandom), 2'($urandom), 4'($urandom),
                       4'($urandom));
      endcase
      case (blk / 2)
        0: begin snd_idle_pct = 15; rcv_idle_pct = 80; end
        1: begin snd_idle_pct = 80; rcv_idle_pct = 15; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 180; n++) pending.push_back(rand_word());
    end

    while (pending.size() != 0 || in_valid || expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
design/mfd_pkg.sv
design/mfd_ram.sv
design/multitap_feedback_delay_unit.sv
design/mfd_checker.sv
test/tb_multitap_feedback_delay_unit.sv
